/* hw/rtl/gamepad_shift_layer_remapper_top_macros.svh */
// ----------------------------------------------------------------------------
// gamepad shift layer remapper assertion macros
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_SHIFT_LAYER_REMAPPER_TOP_MACROS_SVH
`define GAMEPAD_SHIFT_LAYER_REMAPPER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// checked on every edge outside reset
`define GSLR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// checked on every edge, reset included
`define GSLR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GSLR_ASSERT(lbl, prop, msg)
`define GSLR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* hw/rtl/gslr_pkg.sv */
// ----------------------------------------------------------------------------
// gslr_pkg
// types and constants shared by the gamepad shift layer remapper
// ----------------------------------------------------------------------------
`default_nettype none

package gslr_pkg;

	// button word bits
	localparam logic [15:0] BTN_DPAD_UP    = 16'h0001;
	localparam logic [15:0] BTN_DPAD_DOWN  = 16'h0002;
	localparam logic [15:0] BTN_DPAD_LEFT  = 16'h0004;
	localparam logic [15:0] BTN_DPAD_RIGHT = 16'h0008;
	localparam logic [15:0] BTN_START      = 16'h0010;
	localparam logic [15:0] BTN_BACK       = 16'h0020;
	localparam logic [15:0] BTN_RTHUMB     = 16'h0080;
	localparam logic [15:0] BTN_RSHOULDER  = 16'h0200;
	localparam logic [15:0] BTN_A          = 16'h1000;
	localparam logic [15:0] BTN_B          = 16'h2000;
	localparam logic [15:0] BTN_X          = 16'h4000;
	localparam logic [15:0] BTN_Y          = 16'h8000;

	// function key bits
	localparam int KEY_F1 = 0;
	localparam int KEY_F2 = 1;
	localparam int KEY_F3 = 2;
	localparam int KEY_F4 = 3;
	localparam int KEY_F5 = 4;
	localparam int KEY_F6 = 5;
	localparam int KEY_F7 = 6;

	// touch flag bits
	localparam int TF_RIGHT_REST = 0;
	localparam int TF_LEFT_REST  = 1;
	localparam int TF_A_LEFT     = 2;
	localparam int TF_B_LEFT     = 3;
	localparam int TF_A_ANY      = 4;
	localparam int TF_B_ANY      = 5;
	localparam int TF_LEFT_GRIP  = 6;
	localparam int TF_RIGHT_GRIP = 7;

	// haptic request bits
	localparam logic [1:0] HAPTIC_SHORT = 2'b01;
	localparam logic [1:0] HAPTIC_LONG  = 2'b10;

	localparam logic [7:0] TRIGGER_FULL = 8'hFF;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_REMAP_ENABLE        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STICK_PRESS_LEVEL   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STICK_RELEASE_LEVEL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL       = 2'd3;
	localparam int CFG_DATA_W = 15;

	localparam logic [14:0] STICK_PRESS_RESET   = 15'd25000;
	localparam logic [14:0] STICK_RELEASE_RESET = 15'd5000;
	localparam logic [7:0]  TRIGGER_RESET       = 8'd200;

	typedef struct packed {
		logic               controllers_in_use;
		logic [15:0]        button_word;
		logic [7:0]         left_trigger_in;
		logic signed [15:0] left_stick_x_in;
		logic signed [15:0] left_stick_y_in;
		logic signed [15:0] right_stick_x_in;
		logic signed [15:0] right_stick_y_in;
		logic [7:0]         touch_flags;
	} poll_t;

	typedef struct packed {
		logic [15:0]        button_word_out;
		logic [7:0]         left_trigger_out;
		logic signed [15:0] left_stick_x_out;
		logic signed [15:0] left_stick_y_out;
		logic signed [15:0] right_stick_x_out;
		logic signed [15:0] right_stick_y_out;
		logic [6:0]         key_press_mask;
		logic [6:0]         key_release_mask;
		logic [1:0]         haptic_left;
		logic [1:0]         haptic_right;
	} result_t;

	typedef struct packed {
		logic        remap_enable;
		logic [14:0] stick_press_level;
		logic [14:0] stick_release_level;
		logic [7:0]  trigger_level;
	} cfg_t;

	typedef struct packed {
		logic [6:0] keys_held;
		logic       trigger_latched;
		logic       swap_active;
		logic       start_held;
		logic       select_held;
		logic       left_grip_held;
		logic       right_grip_held;
	} remap_state_t;

endpackage

`default_nettype wire

/* hw/rtl/gamepad_shift_layer_remapper_top.sv */
// throughput: one poll per cycle while results are taken; the remap state is
// updated as each poll leaves the input register for the result register, so
// back-to-back polls see each other's state; the result register frees the
// input side while a result waits to be taken
// reset (arst_n low, asynchronous): pipeline empty, all latched keys and flags
// cleared, configuration back to its default levels with remapping disabled
`default_nettype none

`include "gamepad_shift_layer_remapper_top_macros.svh"

module gamepad_shift_layer_remapper_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            poll_valid,
	output logic                                 poll_ready,
	input  wire gslr_pkg::poll_t                 poll,
	output logic                                 result_valid,
	input  wire logic                            result_ready,
	output gslr_pkg::result_t                    result,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [gslr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [gslr_pkg::CFG_DATA_W-1:0] cfg_data
);

	gslr_pkg::cfg_t         cfg;
	gslr_pkg::poll_t        poll_s1;
	logic                   valid_s1;
	gslr_pkg::remap_state_t state_q;
	gslr_pkg::remap_state_t state_next;
	gslr_pkg::result_t      result_next;
	gslr_pkg::result_t      result_q;
	logic                   result_valid_q;
	logic                   advance;

	assign cfg_ready = 1'b1;

	gslr_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	gslr_remap u_remap (
		.poll       (poll_s1),
		.cfg        (cfg),
		.state      (state_q),
		.result     (result_next),
		.state_next (state_next)
	);

	// item moves from the input register to the result register
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign poll_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			state_q        <= '0;
		end else begin
			if (poll_ready) begin
				valid_s1 <= poll_valid;
			end
			if (advance) begin
				result_valid_q <= 1'b1;
				state_q        <= state_next;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (poll_valid && poll_ready) begin
			poll_s1 <= poll;
		end
		if (advance) begin
			result_q <= result_next;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	`GSLR_ASSERT(a_s1_holds_on_stall,
		valid_s1 && result_valid_q && !result_ready |=> valid_s1,
		"queued poll lost while the result side stalled")
	`GSLR_ASSERT(a_state_only_on_advance,
		!advance |=> $stable(state_q),
		"remap state changed without a poll moving on")
	`GSLR_ASSERT(a_release_only_held,
		advance |=> ((result_q.key_release_mask & ~$past(state_q.keys_held)) == '0),
		"release reported for a key that was not held")
	`GSLR_ASSERT(a_press_leaves_held,
		advance |=> ((result_q.key_press_mask & ~state_q.keys_held) == '0),
		"pressed key not left held")
	`GSLR_ASSERT(a_disabled_no_events,
		advance && !cfg.remap_enable |=> (result_q.key_press_mask == '0) &&
			(result_q.key_release_mask == '0) && (result_q.haptic_left == '0) &&
			(result_q.haptic_right == '0),
		"events raised while remapping is disabled")

endmodule

`default_nettype wire

/* hw/rtl/gslr_cfg_regs.sv */
// ----------------------------------------------------------------------------
// gslr_cfg_regs
// configuration register file, written through the cfg channel
// ----------------------------------------------------------------------------
`default_nettype none

module gslr_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [gslr_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [gslr_pkg::CFG_DATA_W-1:0] wr_data,
	output gslr_pkg::cfg_t                      cfg
);

	gslr_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.remap_enable        <= 1'b0;
			cfg_q.stick_press_level   <= gslr_pkg::STICK_PRESS_RESET;
			cfg_q.stick_release_level <= gslr_pkg::STICK_RELEASE_RESET;
			cfg_q.trigger_level       <= gslr_pkg::TRIGGER_RESET;
		end else if (wr_en) begin
			case (wr_index)
				gslr_pkg::CFG_REMAP_ENABLE:        cfg_q.remap_enable <= wr_data[0];
				gslr_pkg::CFG_STICK_PRESS_LEVEL:   cfg_q.stick_press_level <= wr_data;
				gslr_pkg::CFG_STICK_RELEASE_LEVEL: cfg_q.stick_release_level <= wr_data;
				gslr_pkg::CFG_TRIGGER_LEVEL:       cfg_q.trigger_level <= wr_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* hw/rtl/gslr_remap.sv */
// ----------------------------------------------------------------------------
// gslr_remap
// single-pass remap of one poll: releases, shift layers, swap, touches, grips
// ----------------------------------------------------------------------------
`default_nettype none

module gslr_remap (
	input  wire gslr_pkg::poll_t        poll,
	input  wire gslr_pkg::cfg_t         cfg,
	input  wire gslr_pkg::remap_state_t state,
	output gslr_pkg::result_t           result,
	output gslr_pkg::remap_state_t      state_next
);

	always_comb begin
		logic signed [16:0] pl_pos;
		logic signed [16:0] pl_neg;
		logic signed [16:0] rl_pos;
		logic signed [16:0] rl_neg;
		logic signed [16:0] lx;
		logic signed [16:0] ly;
		logic signed [16:0] rx;
		logic signed [16:0] ry;
		logic [15:0]        btn;
		logic [7:0]         lt;
		logic [7:0]         tf;
		logic [6:0]         relm;
		logic [6:0]         pressm;
		logic [6:0]         keys;
		logic [1:0]         hl;
		logic [1:0]         hr;
		logic               trig;
		logic               swap;
		logic               ltp;

		pl_pos = {2'b00, cfg.stick_press_level};
		pl_neg = -pl_pos;
		rl_pos = {2'b00, cfg.stick_release_level};
		rl_neg = -rl_pos;
		lx     = 17'(poll.left_stick_x_in);
		ly     = 17'(poll.left_stick_y_in);
		rx     = 17'(poll.right_stick_x_in);
		ry     = 17'(poll.right_stick_y_in);
		btn    = poll.button_word;
		lt     = poll.left_trigger_in;
		tf     = poll.touch_flags;
		relm   = '0;
		pressm = '0;
		hl     = '0;
		hr     = '0;
		ltp    = 1'b0;
		keys   = state.keys_held;
		trig   = state.trigger_latched;
		swap   = state.swap_active;
		state_next = state;

		if (cfg.remap_enable && poll.controllers_in_use) begin
			// releases judged on the original inputs
			relm[gslr_pkg::KEY_F1] = keys[gslr_pkg::KEY_F1] && ((btn & gslr_pkg::BTN_A) == '0);
			relm[gslr_pkg::KEY_F2] = keys[gslr_pkg::KEY_F2] && ((btn & gslr_pkg::BTN_X) == '0);
			relm[gslr_pkg::KEY_F3] = keys[gslr_pkg::KEY_F3] &&
				((btn & gslr_pkg::BTN_RTHUMB) == '0);
			relm[gslr_pkg::KEY_F5] = keys[gslr_pkg::KEY_F5] && (ry > rl_neg);
			relm[gslr_pkg::KEY_F4] = keys[gslr_pkg::KEY_F4] && (ry < rl_pos);
			relm[gslr_pkg::KEY_F6] = keys[gslr_pkg::KEY_F6] && (rx > rl_neg);
			relm[gslr_pkg::KEY_F7] = keys[gslr_pkg::KEY_F7] && (rx < rl_pos);
			keys = keys & ~relm;
			if (trig && (lt < cfg.trigger_level)) begin
				trig = 1'b0;
			end

			// right rest with B and Y up: left stick to d-pad, checks see earlier zeroing
			if (tf[gslr_pkg::TF_RIGHT_REST] &&
			    ((btn & (gslr_pkg::BTN_B | gslr_pkg::BTN_Y)) == '0)) begin
				if (ly <= pl_neg) begin
					ly  = '0;
					btn = btn | gslr_pkg::BTN_DPAD_DOWN;
				end
				if (ly >= pl_pos) begin
					ly  = '0;
					btn = btn | gslr_pkg::BTN_DPAD_UP;
				end
				if (lx <= pl_neg) begin
					lx  = '0;
					btn = btn | gslr_pkg::BTN_DPAD_LEFT;
				end
				if (lx >= pl_pos) begin
					lx  = '0;
					btn = btn | gslr_pkg::BTN_DPAD_RIGHT;
				end
			end

			// left rest without pad touches: latched key presses
			if (tf[gslr_pkg::TF_LEFT_REST] && !tf[gslr_pkg::TF_A_LEFT] &&
			    !tf[gslr_pkg::TF_B_LEFT]) begin
				if (((btn & gslr_pkg::BTN_A) != '0) && !keys[gslr_pkg::KEY_F1]) begin
					pressm[gslr_pkg::KEY_F1] = 1'b1;
					keys[gslr_pkg::KEY_F1]   = 1'b1;
					btn = btn & ~gslr_pkg::BTN_A;
				end
				if (((btn & gslr_pkg::BTN_X) != '0) && !keys[gslr_pkg::KEY_F2]) begin
					pressm[gslr_pkg::KEY_F2] = 1'b1;
					keys[gslr_pkg::KEY_F2]   = 1'b1;
					btn = btn & ~gslr_pkg::BTN_X;
				end
				if (((btn & gslr_pkg::BTN_RTHUMB) != '0) && !keys[gslr_pkg::KEY_F3]) begin
					pressm[gslr_pkg::KEY_F3] = 1'b1;
					keys[gslr_pkg::KEY_F3]   = 1'b1;
					btn = btn & ~gslr_pkg::BTN_RTHUMB;
				end
				if ((ry <= pl_neg) && !keys[gslr_pkg::KEY_F5]) begin
					pressm[gslr_pkg::KEY_F5] = 1'b1;
					keys[gslr_pkg::KEY_F5]   = 1'b1;
					ry = '0;
				end
				if ((ry >= pl_pos) && !keys[gslr_pkg::KEY_F4]) begin
					pressm[gslr_pkg::KEY_F4] = 1'b1;
					keys[gslr_pkg::KEY_F4]   = 1'b1;
					ry = '0;
				end
				if ((rx <= pl_neg) && !keys[gslr_pkg::KEY_F6]) begin
					pressm[gslr_pkg::KEY_F6] = 1'b1;
					keys[gslr_pkg::KEY_F6]   = 1'b1;
					rx = '0;
				end
				if ((rx >= pl_pos) && !keys[gslr_pkg::KEY_F7]) begin
					pressm[gslr_pkg::KEY_F7] = 1'b1;
					keys[gslr_pkg::KEY_F7]   = 1'b1;
					rx = '0;
				end
				// trigger toggles the lt / rb swap
				if ((lt >= cfg.trigger_level) && !trig) begin
					trig = 1'b1;
					swap = !swap;
					lt   = '0;
					hl   = hl | gslr_pkg::HAPTIC_LONG;
					hr   = hr | gslr_pkg::HAPTIC_LONG;
				end
			end

			if (swap) begin
				ltp = lt >= cfg.trigger_level;
				lt  = ((btn & gslr_pkg::BTN_RSHOULDER) != '0) ? gslr_pkg::TRIGGER_FULL : '0;
				btn = ltp ? (btn | gslr_pkg::BTN_RSHOULDER) : (btn & ~gslr_pkg::BTN_RSHOULDER);
			end

			// start and back follow the pad touches
			btn = btn & ~(gslr_pkg::BTN_START | gslr_pkg::BTN_BACK);
			if (tf[gslr_pkg::TF_A_ANY]) begin
				btn = btn | gslr_pkg::BTN_START;
				if (!state.start_held) begin
					hl = hl | gslr_pkg::HAPTIC_SHORT;
				end
			end
			if (tf[gslr_pkg::TF_B_ANY]) begin
				btn = btn | gslr_pkg::BTN_BACK;
				if (!state.select_held) begin
					hl = hl | gslr_pkg::HAPTIC_SHORT;
				end
			end

			// grip edges
			if (tf[gslr_pkg::TF_LEFT_GRIP] != state.left_grip_held) begin
				hl = hl | gslr_pkg::HAPTIC_SHORT;
			end
			if (tf[gslr_pkg::TF_RIGHT_GRIP] != state.right_grip_held) begin
				hr = hr | gslr_pkg::HAPTIC_SHORT;
			end

			state_next.keys_held       = keys;
			state_next.trigger_latched = trig;
			state_next.swap_active     = swap;
			state_next.start_held      = tf[gslr_pkg::TF_A_ANY];
			state_next.select_held     = tf[gslr_pkg::TF_B_ANY];
			state_next.left_grip_held  = tf[gslr_pkg::TF_LEFT_GRIP];
			state_next.right_grip_held = tf[gslr_pkg::TF_RIGHT_GRIP];
		end

		result.button_word_out   = btn;
		result.left_trigger_out  = lt;
		result.left_stick_x_out  = lx[15:0];
		result.left_stick_y_out  = ly[15:0];
		result.right_stick_x_out = rx[15:0];
		result.right_stick_y_out = ry[15:0];
		result.key_press_mask    = pressm;
		result.key_release_mask  = relm;
		result.haptic_left       = hl;
		result.haptic_right      = hr;
	end

endmodule

`default_nettype wire
